>>> design/plbcs_pkg.sv
// Shared types and constants for the priority LED blink-code sequencer.
`timescale 1ns / 1ps
`default_nettype none

package plbcs_pkg;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_SET    = 2'd1,
    ACT_TOGGLE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    PH_GAP = 3'b001,
    PH_ON  = 3'b010,
    PH_OFF = 3'b100
  } led_phase_e;

  typedef enum logic [2:0] {
    REG_SLOW_ON  = 3'd0,
    REG_SLOW_OFF = 3'd1,
    REG_CODE_ON  = 3'd2,
    REG_CODE_OFF = 3'd3,
    REG_CODE_GAP = 3'd4,
    REG_LASER_LIM = 3'd5,
    REG_LED_INV  = 3'd6
  } reg_idx_e;

  localparam int DUR_W      = 12;
  localparam int LIMIT_W    = 8;
  localparam int PRESCALE_W = 10;
  localparam int IDX_IN_W   = 2;
  localparam int OUT_CNT_W  = 16;
  localparam int ACTIVE_W   = 3;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [DUR_W-1:0]   SLOW_ON_RST   = 12'd500;
  localparam logic [DUR_W-1:0]   SLOW_OFF_RST  = 12'd500;
  localparam logic [DUR_W-1:0]   CODE_ON_RST   = 12'd250;
  localparam logic [DUR_W-1:0]   CODE_OFF_RST  = 12'd260;
  localparam logic [DUR_W-1:0]   CODE_GAP_RST  = 12'd1500;
  localparam logic [LIMIT_W-1:0] LASER_LIM_RST = 8'd180;
  localparam logic               LED_INV_RST   = 1'b1;

  localparam logic [PRESCALE_W-1:0] MS_WRAP = 10'd999;
  localparam logic [7:0]            ERR_FLAGS_RST = 8'h0B;

  typedef struct packed {
    logic [DUR_W-1:0]   slow_on;
    logic [DUR_W-1:0]   slow_off;
    logic [DUR_W-1:0]   code_on;
    logic [DUR_W-1:0]   code_off;
    logic [DUR_W-1:0]   code_gap;
    logic [LIMIT_W-1:0] laser_limit;
    logic               led_invert;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic restart;
  } led_ctrl_t;

endpackage

`default_nettype wire

>>> design/plbcs_led_seq.sv
// Status LED phase sequencer: slow blink for code 0, gap plus blink burst otherwise.
`timescale 1ns / 1ps
`default_nettype none

module plbcs_led_seq
  import plbcs_pkg::*;
#(
  parameter int CODE_W = 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire led_ctrl_t         ctrl_i,
  input  wire logic [CODE_W-1:0] code_i,
  input  wire cfg_t              cfg_i,
  output logic                   led_on_o
);

  localparam int BD_W = CODE_W + 1;

  led_phase_e        phase_q, phase_d;
  logic [DUR_W-1:0]  ms_q, ms_d;
  logic [BD_W-1:0]   bd_q, bd_d, bd_inc, code_p1;
  logic [CODE_W-1:0] code_q, code_d;

  always_comb begin
    phase_d = phase_q;
    ms_d    = ms_q;
    bd_d    = bd_q;
    code_d  = code_q;
    bd_inc  = bd_q + 1'b1;
    code_p1 = {1'b0, code_q} + 1'b1;
    if (ctrl_i.restart) begin
      code_d = code_i;
      bd_d   = '0;
      if (code_i == '0) begin
        phase_d = PH_ON;
        ms_d    = cfg_i.slow_on;
      end else begin
        phase_d = PH_GAP;
        ms_d    = cfg_i.code_gap;
      end
    end else if (ctrl_i.tick) begin
      if (ms_q > DUR_W'(1)) begin
        ms_d = ms_q - 1'b1;
      end else if (code_q == '0) begin
        if (phase_q == PH_ON) begin
          phase_d = PH_OFF;
          ms_d    = cfg_i.slow_off;
        end else begin
          phase_d = PH_ON;
          ms_d    = cfg_i.slow_on;
        end
      end else begin
        unique case (phase_q)
          PH_ON: begin
            phase_d = PH_OFF;
            ms_d    = cfg_i.code_off;
          end
          PH_OFF: begin
            if (bd_inc >= code_p1) begin
              bd_d    = '0;
              phase_d = PH_GAP;
              ms_d    = cfg_i.code_gap;
            end else begin
              bd_d    = bd_inc;
              phase_d = PH_ON;
              ms_d    = cfg_i.code_on;
            end
          end
          default: begin
            bd_d    = '0;
            phase_d = PH_ON;
            ms_d    = cfg_i.code_on;
          end
        endcase
      end
    end
  end

  // next-state level, registered into the result stage by the parent
  assign led_on_o = (phase_d == PH_ON);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GAP;
      ms_q    <= CODE_GAP_RST;
      bd_q    <= '0;
      code_q  <= CODE_W'(1);
    end else begin
      phase_q <= phase_d;
      ms_q    <= ms_d;
      bd_q    <= bd_d;
      code_q  <= code_d;
    end
  end

endmodule

`default_nettype wire

>>> design/priority_led_blink_code_sequencer_unit.sv
// Top level: stream ports, APB registers, error flags, laser timer, result stage.
//
//  Channel  | Direction | Contents
//  s_axis   | in        | tuser: action; tdata: error_index, error_active
//  m_axis   | out       | tdata: led_level, laser_level, active_error, laser_enabled,
//           |           |        flag_transitions
//  apb      | in/out    | register writes and reads, pready tied high
//
// One beat per cycle sustained while m_axis_tready is high. An accepted beat is registered
// in the input register, where its state update and result are computed; the result loads
// into the output register when the beat fires, which raises m_axis_tvalid. A stalled
// output holds the input register; s_axis_tready drops only when both stages are full
// and m_axis_tready is low.
// Reset is asynchronous, active low, and restores all but the beat data registers.
`timescale 1ns / 1ps
`default_nettype none

module priority_led_blink_code_sequencer_unit
  import plbcs_pkg::*;
#(
  parameter int NUM_ERRORS  = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [1:0] error_index, [2] error_active
  input  wire logic [1:0]        s_axis_tuser,   // [1:0] action
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [0] led_level, [1] laser_level, [4:2] active_error, [5] laser_enabled,
  // [21:6] flag_transitions
  output logic [23:0]            m_axis_tdata,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam int CODE_W = $clog2(NUM_ERRORS + 1);

  // ---------------- registers ----------------
  cfg_t cfg_q;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slow_on     <= SLOW_ON_RST;
      cfg_q.slow_off    <= SLOW_OFF_RST;
      cfg_q.code_on     <= CODE_ON_RST;
      cfg_q.code_off    <= CODE_OFF_RST;
      cfg_q.code_gap    <= CODE_GAP_RST;
      cfg_q.laser_limit <= LASER_LIM_RST;
      cfg_q.led_invert  <= LED_INV_RST;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_SLOW_ON:   cfg_q.slow_on     <= pwdata[DUR_W-1:0];
        REG_SLOW_OFF:  cfg_q.slow_off    <= pwdata[DUR_W-1:0];
        REG_CODE_ON:   cfg_q.code_on     <= pwdata[DUR_W-1:0];
        REG_CODE_OFF:  cfg_q.code_off    <= pwdata[DUR_W-1:0];
        REG_CODE_GAP:  cfg_q.code_gap    <= pwdata[DUR_W-1:0];
        REG_LASER_LIM: cfg_q.laser_limit <= pwdata[LIMIT_W-1:0];
        REG_LED_INV:   cfg_q.led_invert  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SLOW_ON:   prdata = DATA_W'(cfg_q.slow_on);
      REG_SLOW_OFF:  prdata = DATA_W'(cfg_q.slow_off);
      REG_CODE_ON:   prdata = DATA_W'(cfg_q.code_on);
      REG_CODE_OFF:  prdata = DATA_W'(cfg_q.code_off);
      REG_CODE_GAP:  prdata = DATA_W'(cfg_q.code_gap);
      REG_LASER_LIM: prdata = DATA_W'(cfg_q.laser_limit);
      REG_LED_INV:   prdata = DATA_W'(cfg_q.led_invert);
      default:       prdata = '0;
    endcase
  end

  // ---------------- input stage ----------------
  logic                in_valid_q;
  action_e             in_act_q;
  logic [IDX_IN_W-1:0] in_idx_q;
  logic                in_active_q;
  logic                out_valid_q;
  logic                fire;

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_act_q    <= action_e'(s_axis_tuser);
      in_idx_q    <= s_axis_tdata[IDX_IN_W-1:0];
      in_active_q <= s_axis_tdata[IDX_IN_W];
    end
  end

  // ---------------- error flags and counters ----------------
  logic [NUM_ERRORS-1:0]  flags_q, flags_d, hit;
  logic [COUNT_WIDTH-1:0] cnt_q [NUM_ERRORS];
  logic [COUNT_WIDTH-1:0] cnt_d [NUM_ERRORS];
  logic [COUNT_WIDTH-1:0] cnt_sel;
  logic [31:0]            cnt_ext;
  logic [CODE_W-1:0]      code_new;
  logic                   set_ev;

  always_comb begin
    for (int i = 0; i < NUM_ERRORS; i++) begin
      hit[i] = (32'(in_idx_q) == i);
    end
    set_ev  = fire && (in_act_q == ACT_SET) && (|hit);
    flags_d = flags_q;
    cnt_sel = '0;
    for (int i = 0; i < NUM_ERRORS; i++) begin
      cnt_d[i] = cnt_q[i];
      if (set_ev && hit[i]) begin
        flags_d[i] = in_active_q;
        if ((flags_q[i] != in_active_q) && (cnt_q[i] != '1)) begin
          cnt_d[i] = cnt_q[i] + 1'b1;
        end
      end
      if (hit[i]) begin
        cnt_sel = cnt_sel | cnt_d[i];
      end
    end
    // lowest active index wins
    code_new = '0;
    for (int i = NUM_ERRORS - 1; i >= 0; i--) begin
      if (flags_d[i]) begin
        code_new = CODE_W'(i + 1);
      end
    end
  end

  assign cnt_ext = 32'(cnt_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= NUM_ERRORS'(ERR_FLAGS_RST);
      for (int i = 0; i < NUM_ERRORS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      flags_q <= flags_d;
      for (int i = 0; i < NUM_ERRORS; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  // ---------------- status LED ----------------
  led_ctrl_t led_ctrl;
  logic      led_on_d;

  assign led_ctrl.tick    = fire && (in_act_q == ACT_TICK);
  assign led_ctrl.restart = set_ev;

  plbcs_led_seq #(
    .CODE_W (CODE_W)
  ) u_led_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (led_ctrl),
    .code_i   (code_new),
    .cfg_i    (cfg_q),
    .led_on_o (led_on_d)
  );

  // ---------------- laser blink and timeout ----------------
  logic                  lz_phase_q, lz_phase_d;
  logic [DUR_W-1:0]      lz_ms_q, lz_ms_d;
  logic                  lz_on_q, lz_on_d;
  logic [PRESCALE_W-1:0] presc_q, presc_d;
  logic [LIMIT_W-1:0]    lz_sec_q, lz_sec_d;

  always_comb begin
    lz_phase_d = lz_phase_q;
    lz_ms_d    = lz_ms_q;
    lz_on_d    = lz_on_q;
    presc_d    = presc_q;
    lz_sec_d   = lz_sec_q;
    if (fire && (in_act_q == ACT_TICK)) begin
      if (lz_ms_q > DUR_W'(1)) begin
        lz_ms_d = lz_ms_q - 1'b1;
      end else begin
        lz_phase_d = !lz_phase_q;
        lz_ms_d    = lz_phase_q ? cfg_q.slow_off : cfg_q.slow_on;
      end
      if (presc_q >= MS_WRAP) begin
        presc_d = '0;
        if (lz_on_q) begin
          if (lz_sec_q >= cfg_q.laser_limit) begin
            lz_on_d  = 1'b0;
            lz_sec_d = '0;
          end else begin
            lz_sec_d = lz_sec_q + 1'b1;
          end
        end
      end else begin
        presc_d = presc_q + 1'b1;
      end
    end else if (fire && (in_act_q == ACT_TOGGLE)) begin
      lz_on_d  = !lz_on_q;
      lz_sec_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lz_phase_q <= 1'b1;
      lz_ms_q    <= SLOW_ON_RST;
      lz_on_q    <= 1'b0;
      presc_q    <= '0;
      lz_sec_q   <= '0;
    end else begin
      lz_phase_q <= lz_phase_d;
      lz_ms_q    <= lz_ms_d;
      lz_on_q    <= lz_on_d;
      presc_q    <= presc_d;
      lz_sec_q   <= lz_sec_d;
    end
  end

  // ---------------- result stage ----------------
  logic                 out_led_q, out_laser_q, out_lz_en_q;
  logic [ACTIVE_W-1:0]  out_active_q;
  logic [OUT_CNT_W-1:0] out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_led_q    <= led_on_d ^ cfg_q.led_invert;
      out_laser_q  <= lz_phase_d && lz_on_d;
      out_active_q <= ACTIVE_W'(code_new);
      out_lz_en_q  <= lz_on_d;
      out_cnt_q    <= cnt_ext[OUT_CNT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_cnt_q, out_lz_en_q, out_active_q, out_laser_q, out_led_q};

  // ---------------- assertions ----------------
  a_in_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> in_valid_q)
    else $error("accepted beat not held in input stage");

  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed beat produced no result");

  a_laser_gate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_laser_q || out_lz_en_q))
    else $error("laser level high while laser disabled");

  a_active_rng : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (32'(out_active_q) <= NUM_ERRORS))
    else $error("active error code out of range");

endmodule

`default_nettype wire
